[rtl/core/sm3he_pkg.sv]
// ----------------------------------------------------------------------------
// sm3he_pkg
// Shared types, constants and bit functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3he_pkg;

	localparam logic [31:0] SM3_IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};
	localparam logic [31:0] SM3_T_LOW  = 32'h79CC4519;
	localparam logic [31:0] SM3_T_HIGH = 32'h7A879D8A;
	localparam logic [7:0]  PAD_BYTE   = 8'h80;

	// Rotate left; an amount of zero leaves the word as it is.
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		rotl32 = (x << n) | (x >> (6'd32 - {1'b0, n}));
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		perm0 = x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		perm1 = x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
	endfunction

	// Round constant of round 16, already rotated by 16.
	localparam logic [31:0] SM3_T_HIGH_R16 = rotl32(SM3_T_HIGH, 5'd16);

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_input;
	} sm3he_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_of_run;
	} sm3he_out_t;

	// Control of the block buffer / expansion window.
	typedef struct packed {
		logic       wr_en;
		logic [3:0] idx;
		logic [1:0] lane;
		logic [7:0] wr_byte;
		logic       shift;
	} msg_ctl_t;

	typedef struct packed {
		logic [31:0] w;
		logic [31:0] w4;
	} msg_words_t;

	// Control and status of the round unit.
	typedef struct packed {
		logic       start;
		logic       init;
		logic [2:0] out_sel;
	} rnd_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rnd_stat_t;

endpackage

[rtl/core/sm3he_msg.sv]
// ----------------------------------------------------------------------------
// sm3he_msg
// Block buffer that doubles as the 16-word message expansion window.
// ----------------------------------------------------------------------------
module sm3he_msg import sm3he_pkg::*; (
	input  logic       clk,
	input  msg_ctl_t   ctl,
	output msg_words_t words
);

	logic [31:0] win_q [16];
	logic [31:0] w_new;

	// W[j+16] from the window holding W[j] .. W[j+15]
	assign w_new = perm1(win_q[0] ^ win_q[7] ^ rotl32(win_q[13], 5'd15))
		^ rotl32(win_q[3], 5'd7) ^ win_q[10];

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int k = 0; k < 15; k++) begin
				win_q[k] <= win_q[k + 1];
			end
			win_q[15] <= w_new;
		end else if (ctl.wr_en) begin
			win_q[ctl.idx][{~ctl.lane, 3'b000} +: 8] <= ctl.wr_byte;
		end
	end

	assign words.w  = win_q[0];
	assign words.w4 = win_q[4];

endmodule

[rtl/core/sm3he_round.sv]
// ----------------------------------------------------------------------------
// sm3he_round
// Chaining value and the SM3 round unit, one round per cycle over the 64 rounds of a block.
// ----------------------------------------------------------------------------
module sm3he_round import sm3he_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rnd_ctl_t    ctl,
	input  msg_words_t  words,
	output rnd_stat_t   stat,
	output logic [31:0] chain_word
);

	logic [31:0] chain_q [8];
	logic [31:0] r_q [8];
	logic [31:0] r_nxt [8];
	logic [31:0] tj_q;
	logic [5:0]  j_q;
	logic        busy_q;
	logic        done;
	logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;

	always_comb begin
		a12 = rotl32(r_q[0], 5'd12);
		ss1 = rotl32(a12 + r_q[4] + tj_q, 5'd7);
		ss2 = ss1 ^ a12;
		if (j_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (words.w ^ words.w4);
		tt2 = gg + r_q[7] + ss1 + words.w;
		r_nxt[0] = tt1;
		r_nxt[1] = r_q[0];
		r_nxt[2] = rotl32(r_q[1], 5'd9);
		r_nxt[3] = r_q[2];
		r_nxt[4] = perm0(tt2);
		r_nxt[5] = r_q[4];
		r_nxt[6] = rotl32(r_q[5], 5'd19);
		r_nxt[7] = r_q[6];
	end

	assign done = busy_q && (j_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			j_q    <= '0;
			for (int k = 0; k < 8; k++) begin
				chain_q[k] <= SM3_IV[k];
			end
		end else begin
			if (ctl.start) begin
				busy_q <= 1'b1;
				j_q    <= '0;
			end else if (busy_q) begin
				busy_q <= !done;
				j_q    <= j_q + 6'd1;
			end
			// fold the working registers into the chain on the last round
			if (ctl.init) begin
				for (int k = 0; k < 8; k++) begin
					chain_q[k] <= SM3_IV[k];
				end
			end else if (done) begin
				for (int k = 0; k < 8; k++) begin
					chain_q[k] <= chain_q[k] ^ r_nxt[k];
				end
			end
		end
	end

	// rotl(T, j) tracked by a one-bit rotate each round, reloaded with the round-16 constant after round 15
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			tj_q <= SM3_T_LOW;
			for (int k = 0; k < 8; k++) begin
				r_q[k] <= chain_q[k];
			end
		end else if (busy_q) begin
			tj_q <= (j_q == 6'd15) ? SM3_T_HIGH_R16 : rotl32(tj_q, 5'd1);
			for (int k = 0; k < 8; k++) begin
				r_q[k] <= r_nxt[k];
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.done  = done;
	assign chain_word = chain_q[ctl.out_sel];

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy_q)
		else $error("round unit still busy after its last round");

	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !done && !ctl.start) |=> (j_q == $past(j_q) + 6'd1))
		else $error("round counter skipped");

endmodule

[rtl/core/sm3_hash_engine.sv]
// ----------------------------------------------------------------------------
// sm3_hash_engine
// SM3 hash over a stream of big-endian message words, 256-bit digest out.
// ----------------------------------------------------------------------------
// A message enters as 32-bit words, first byte in bits 31..24, each word with
// a byte count (values above four count as four) and a last flag. The engine
// takes one word at a time: in_ready is high only while it waits for a word.
// Bytes go into the 64-byte block buffer one per cycle while no block is
// being compressed. Each filled block runs through the round unit, one SM3
// round per cycle, and byte loading weighs more than the rounds. On a word
// marked last the engine appends the 0x80 pad byte, zero bytes and the
// 64-bit bit length, one byte per cycle outside compression, compressing one
// or two more blocks, then presents the digest as eight words (word_index 0
// first, last_of_run on word 7) through an output register. It then returns
// to the initial vector and accepts the next message while the last digest
// word may still wait to be taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sm3_hash_engine import sm3he_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sm3he_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output sm3he_out_t out_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_BYTE   = 3'd1;
	localparam logic [2:0] ST_PAD80  = 3'd2;
	localparam logic [2:0] ST_PADZ   = 3'd3;
	localparam logic [2:0] ST_PADLEN = 3'd4;
	localparam logic [2:0] ST_COMP   = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]  state_q, ret_q;
	logic [5:0]  fill_q;
	logic [63:0] msg_bits_q;
	logic [2:0]  sel_q, cnt_q;
	logic [31:0] data_q;
	logic        last_q;
	logic [2:0]  out_idx_q;
	logic        out_valid_q;
	sm3he_out_t  out_q;

	msg_ctl_t    mctl;
	msg_words_t  mwords;
	rnd_ctl_t    rctl;
	rnd_stat_t   rstat;
	logic [31:0] chain_word;

	logic        put;
	logic        wrap;
	logic        load;
	logic [7:0]  put_byte;

	// Pick the byte written this cycle, if any.
	always_comb begin
		put      = 1'b0;
		put_byte = '0;
		unique case (state_q)
			ST_BYTE: begin
				put      = sel_q < cnt_q;
				put_byte = data_q[{~sel_q[1:0], 3'b000} +: 8];
			end
			ST_PAD80: begin
				put      = 1'b1;
				put_byte = PAD_BYTE;
			end
			ST_PADZ: begin
				put      = fill_q != 6'd56;
				put_byte = '0;
			end
			ST_PADLEN: begin
				put      = 1'b1;
				put_byte = msg_bits_q[{~fill_q[2:0], 3'b000} +: 8];
			end
			default: begin
				put      = 1'b0;
				put_byte = '0;
			end
		endcase
	end

	assign wrap = put && (fill_q == 6'd63);
	assign load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign mctl.wr_en   = put;
	assign mctl.idx     = fill_q[5:2];
	assign mctl.lane    = fill_q[1:0];
	assign mctl.wr_byte = put_byte;
	assign mctl.shift   = rstat.busy;

	assign rctl.start   = wrap;
	assign rctl.init    = load && (out_idx_q == 3'd7);
	assign rctl.out_sel = out_idx_q;

	sm3he_msg u_msg (
		.clk   (clk),
		.ctl   (mctl),
		.words (mwords)
	);

	sm3he_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rctl),
		.words      (mwords),
		.stat       (rstat),
		.chain_word (chain_word)
	);

	// Sequencer: bytes in, padding, compression, digest out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			msg_bits_q  <= '0;
			sel_q       <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (put) begin
				fill_q <= fill_q + 6'd1;
			end
			if (out_valid_q && out_ready && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sel_q   <= '0;
						state_q <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					if (put) begin
						sel_q      <= sel_q + 3'd1;
						msg_bits_q <= msg_bits_q + 64'd8;
						if (wrap) begin
							ret_q   <= ST_BYTE;
							state_q <= ST_COMP;
						end
					end else begin
						state_q <= last_q ? ST_PAD80 : ST_IDLE;
					end
				end
				ST_PAD80: begin
					ret_q   <= ST_PADZ;
					state_q <= wrap ? ST_COMP : ST_PADZ;
				end
				ST_PADZ: begin
					if (!put) begin
						state_q <= ST_PADLEN;
					end else if (wrap) begin
						ret_q   <= ST_PADZ;
						state_q <= ST_COMP;
					end
				end
				ST_PADLEN: begin
					if (wrap) begin
						ret_q   <= ST_OUT;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (rstat.done) begin
						state_q <= ret_q;
					end
				end
				ST_OUT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							// drop back to the initial state for the next message
							fill_q     <= '0;
							msg_bits_q <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted word and the digest word on offer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data.data_word;
			cnt_q  <= (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
			last_q <= in_data.last_input;
		end
		if (load) begin
			out_q.digest_word <= chain_word;
			out_q.word_index  <= out_idx_q;
			out_q.last_of_run <= out_idx_q == 3'd7;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_comp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> rstat.busy)
		else $error("waiting on compression while the round unit is idle");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rstat.busy)
		else $error("round unit busy while taking words");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PADLEN) |-> (fill_q >= 6'd56))
		else $error("length bytes written outside the last eight bytes");

endmodule
